/* sv/assert_macros.svh */
// Assertion macros shared by the statistics table RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* sv/kts_pkg.sv */
// Package for the keyed timing statistics table: field widths, defaults, request
// modes and the sequencer state type. Depends on nothing.
package kts_pkg;

   localparam int ENTRIES_DEFAULT  = 32;
   localparam int KEY_BITS_DEFAULT = 32;

   localparam int KEY_IN_BITS = 32;
   localparam int DUR_BITS    = 32;
   localparam int CNT_BITS    = 32;
   localparam int SUM_BITS    = 64;
   localparam int IDX_BITS    = 5;

   localparam logic [DUR_BITS-1:0] MIN_START_RESET = 32'd255999744;

   // Request modes.
   localparam logic MODE_RECORD = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_CLEAR,
      ST_FINISH
   } state_type;

endpackage

/* sv/keyed_timing_statistics_table.sv */
// Keyed timing statistics table: top level with key search sequencer and
// statistics memories. Depends on kts_pkg and assert_macros.svh.
//
// Usage: a request carries a mode, a section key and a duration. In record
// mode the block scans the stored keys one per cycle through a single shared
// comparator; an unknown key takes the next free entry, or is dropped with a
// zero response that raises the full flag if the table is full. The entry's
// total, count, minimum and maximum are updated and returned as one response.
// A request in reset mode clears the statistics of all allocated entries, one
// entry per cycle, and returns a response with every field zero.
// A record request reads the keys through a registered read port and compares
// each against the request key, then updates the entry in the update state.
// Only one request is in flight: a new request is taken only once the response
// of the last one has been loaded.
// The response sits in an output register; if the receiver stalls, the
// sequencer waits in its final state until that register frees up, and
// req_ready stays low. After reset no entries are allocated and the minimum
// start value holds its reset value. The configuration write is taken at
// once and must only be issued while the block is idle.
`include "assert_macros.svh"

module keyed_timing_statistics_table #(
   parameter int ENTRIES  = kts_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS = kts_pkg::KEY_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic [kts_pkg::KEY_IN_BITS-1:0]   req_section_key,
   input  logic [kts_pkg::DUR_BITS-1:0]      req_duration,
   // Response channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [kts_pkg::IDX_BITS-1:0]      rsp_entry_index,
   output logic [kts_pkg::CNT_BITS-1:0]      rsp_call_count,
   output logic [kts_pkg::SUM_BITS-1:0]      rsp_total_time,
   output logic [kts_pkg::DUR_BITS-1:0]      rsp_min_time,
   output logic [kts_pkg::DUR_BITS-1:0]      rsp_max_time,
   output logic                              rsp_table_full,
   // Configuration port for the minimum start value.
   input  logic                              csr_wr_en,
   input  logic [kts_pkg::DUR_BITS-1:0]      csr_wr_data
);

   // Only the low bits of the key that fit both the stored width and the
   // request field take part in the comparison.
   localparam int KW  = (KEY_BITS < kts_pkg::KEY_IN_BITS) ? KEY_BITS : kts_pkg::KEY_IN_BITS;
   localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW  = $clog2(ENTRIES + 1);
   localparam int EXW = (IW > kts_pkg::IDX_BITS) ? IW : kts_pkg::IDX_BITS;

   localparam int DW = kts_pkg::DUR_BITS;
   localparam int NW = kts_pkg::CNT_BITS;
   localparam int SW = kts_pkg::SUM_BITS;

   // Sequencer and control state.
   kts_pkg::state_type state_ff, state_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0] entry_ff, entry_in;
   logic          fresh_ff, fresh_in;
   logic          full_ff, full_in;
   logic [DW-1:0] start_ff;

   // Latched request.
   logic          mode_ff;
   logic [KW-1:0] key_ff;
   logic [DW-1:0] dur_ff;

   // Memories and their registered read data.
   logic [KW-1:0] key_mem   [ENTRIES];
   logic [SW-1:0] sum_mem   [ENTRIES];
   logic [NW-1:0] count_mem [ENTRIES];
   logic [DW-1:0] min_mem   [ENTRIES];
   logic [DW-1:0] max_mem   [ENTRIES];

   logic [KW-1:0] key_rd_ff;
   logic [SW-1:0] sum_rd_ff;
   logic [NW-1:0] count_rd_ff;
   logic [DW-1:0] min_rd_ff;
   logic [DW-1:0] max_rd_ff;

   // Memory controls.
   logic          key_rd_en;
   logic          key_wr_en;
   logic          stat_rd_en;
   logic [IW-1:0] stat_rd_addr;
   logic          stat_wr_en;
   logic [IW-1:0] stat_wr_addr;
   logic [SW-1:0] stat_wr_sum;
   logic [NW-1:0] stat_wr_count;
   logic [DW-1:0] stat_wr_min;
   logic [DW-1:0] stat_wr_max;

   // Response register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_load;
   logic [kts_pkg::IDX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [NW-1:0] rsp_count_ff, rsp_count_in;
   logic [SW-1:0] rsp_total_ff, rsp_total_in;
   logic [DW-1:0] rsp_min_ff, rsp_min_in;
   logic [DW-1:0] rsp_max_ff, rsp_max_in;
   logic          rsp_full_ff, rsp_full_in;

   // Update arithmetic.
   logic [SW-1:0] base_sum;
   logic [NW-1:0] base_count;
   logic [DW-1:0] base_min;
   logic [DW-1:0] base_max;
   logic [SW:0]   sum_wide;
   logic [SW-1:0] new_sum;
   logic [NW-1:0] new_count;
   logic [DW-1:0] new_min;
   logic [DW-1:0] new_max;
   logic [EXW-1:0] entry_ext;

   logic          req_accept;
   logic          rsp_free;
   logic          key_hit;

   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign key_hit    = cmp_valid_ff && (key_rd_ff == key_ff);

   // A freshly allocated entry starts from cleared statistics rather than
   // from whatever the memory holds at that address.
   always_comb begin
      base_sum   = fresh_ff ? '0 : sum_rd_ff;
      base_count = fresh_ff ? '0 : count_rd_ff;
      base_min   = fresh_ff ? start_ff : min_rd_ff;
      base_max   = fresh_ff ? '0 : max_rd_ff;

      sum_wide  = {1'b0, base_sum} + (SW + 1)'(dur_ff);
      new_sum   = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
      new_count = (base_count == '1) ? base_count : base_count + 1'b1;
      new_min   = (dur_ff < base_min) ? dur_ff : base_min;
      new_max   = (dur_ff > base_max) ? dur_ff : base_max;
      entry_ext = EXW'(entry_ff);
   end

   // Sequencer: next state and datapath controls.
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      idx_in       = idx_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = idx_ff[IW-1:0];
      entry_in     = entry_ff;
      fresh_in     = fresh_ff;
      full_in      = full_ff;

      req_ready    = 1'b0;
      key_rd_en    = 1'b0;
      key_wr_en    = 1'b0;
      stat_rd_en   = 1'b0;
      stat_rd_addr = cmp_idx_ff;
      stat_wr_en   = 1'b0;
      stat_wr_addr = entry_ff;
      stat_wr_sum  = new_sum;
      stat_wr_count = new_count;
      stat_wr_min  = new_min;
      stat_wr_max  = new_max;

      rsp_load     = 1'b0;
      rsp_index_in = '0;
      rsp_count_in = '0;
      rsp_total_in = '0;
      rsp_min_in   = '0;
      rsp_max_in   = '0;
      rsp_full_in  = 1'b0;

      unique case (state_ff)
         kts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               idx_in  = '0;
               full_in = 1'b0;
               if (req_mode == kts_pkg::MODE_RECORD) begin
                  state_in = kts_pkg::ST_SCAN;
               end else if (used_ff == '0) begin
                  state_in = kts_pkg::ST_FINISH;
               end else begin
                  state_in = kts_pkg::ST_CLEAR;
               end
            end
         end

         kts_pkg::ST_SCAN: begin
            // One key read is issued per cycle while the compare of the
            // previous read runs, so the scan is one entry per cycle.
            priority if (key_hit) begin
               stat_rd_en   = 1'b1;
               stat_rd_addr = cmp_idx_ff;
               entry_in     = cmp_idx_ff;
               fresh_in     = 1'b0;
               state_in     = kts_pkg::ST_UPDATE;
            end else if (idx_ff == used_ff) begin
               if (used_ff == CW'(ENTRIES)) begin
                  full_in  = 1'b1;
                  state_in = kts_pkg::ST_FINISH;
               end else begin
                  entry_in = used_ff[IW-1:0];
                  fresh_in = 1'b1;
                  state_in = kts_pkg::ST_UPDATE;
               end
            end else begin
               key_rd_en    = 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = idx_ff[IW-1:0];
               idx_in       = idx_ff + 1'b1;
            end
         end

         kts_pkg::ST_UPDATE: begin
            // The write-back and the new key commit together with the
            // response, so a stalled receiver leaves the stores untouched.
            if (rsp_free) begin
               stat_wr_en   = 1'b1;
               key_wr_en    = fresh_ff;
               used_in      = fresh_ff ? used_ff + 1'b1 : used_ff;
               rsp_load     = 1'b1;
               rsp_index_in = entry_ext[kts_pkg::IDX_BITS-1:0];
               rsp_count_in = new_count;
               rsp_total_in = new_sum;
               rsp_min_in   = new_min;
               rsp_max_in   = new_max;
               state_in     = kts_pkg::ST_IDLE;
            end
         end

         kts_pkg::ST_CLEAR: begin
            stat_wr_en    = 1'b1;
            stat_wr_addr  = idx_ff[IW-1:0];
            stat_wr_sum   = '0;
            stat_wr_count = '0;
            stat_wr_min   = start_ff;
            stat_wr_max   = '0;
            idx_in        = idx_ff + 1'b1;
            if (idx_ff == used_ff - 1'b1) begin
               state_in = kts_pkg::ST_FINISH;
            end
         end

         kts_pkg::ST_FINISH: begin
            // Reset requests and dropped keys both answer with zero
            // statistics; only the dropped key raises the full flag.
            if (rsp_free) begin
               rsp_load    = 1'b1;
               rsp_full_in = full_ff;
               state_in    = kts_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = kts_pkg::ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kts_pkg::ST_IDLE;
         used_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= kts_pkg::MIN_START_RESET;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            start_ff <= csr_wr_data;
         end
      end
   end

   // Working registers and the latched request.
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      entry_ff   <= entry_in;
      fresh_ff   <= fresh_in;
      full_ff    <= full_in;
      if (req_accept) begin
         mode_ff <= req_mode;
         key_ff  <= req_section_key[KW-1:0];
         dur_ff  <= req_duration;
      end
   end

   // Key memory: one read port for the scan, one write port for allocation.
   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem[entry_ff] <= key_ff;
      end
      if (key_rd_en) begin
         key_rd_ff <= key_mem[idx_ff[IW-1:0]];
      end
   end

   // Statistics memories, read and written at one address each.
   always_ff @(posedge clock) begin
      if (stat_wr_en) begin
         sum_mem[stat_wr_addr]   <= stat_wr_sum;
         count_mem[stat_wr_addr] <= stat_wr_count;
         min_mem[stat_wr_addr]   <= stat_wr_min;
         max_mem[stat_wr_addr]   <= stat_wr_max;
      end
      if (stat_rd_en) begin
         sum_rd_ff   <= sum_mem[stat_rd_addr];
         count_rd_ff <= count_mem[stat_rd_addr];
         min_rd_ff   <= min_mem[stat_rd_addr];
         max_rd_ff   <= max_mem[stat_rd_addr];
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= rsp_index_in;
         rsp_count_ff <= rsp_count_in;
         rsp_total_ff <= rsp_total_in;
         rsp_min_ff   <= rsp_min_in;
         rsp_max_ff   <= rsp_max_in;
         rsp_full_ff  <= rsp_full_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_call_count  = rsp_count_ff;
   assign rsp_total_time  = rsp_total_ff;
   assign rsp_min_time    = rsp_min_ff;
   assign rsp_max_time    = rsp_max_ff;
   assign rsp_table_full  = rsp_full_ff;

   // The allocation count never passes the table size and grows by at most
   // one entry per cycle.
   `ASSERT_IMPLIES(a_used_bound, clock, reset, 1'b1, used_ff <= CW'(ENTRIES))
   `ASSERT_NEXT(a_used_step, clock, reset, 1'b1, (used_ff == $past(used_ff)) || (used_ff == $past(used_ff) + 1'b1))
   // A dropped key reports no entry and no statistics.
   `ASSERT_IMPLIES(a_full_zero, clock, reset, rsp_valid_ff && rsp_full_ff, (rsp_count_ff == '0) && (rsp_total_ff == '0) && (rsp_index_ff == '0))
   // Any recorded entry has its minimum no larger than its maximum and its
   // total at least as large as its maximum.
   `ASSERT_IMPLIES(a_stats_order, clock, reset, rsp_valid_ff && (rsp_count_ff != '0), (rsp_min_ff <= rsp_max_ff) && (rsp_total_ff >= SW'(rsp_max_ff)))
   // A request in flight leaves ready low.
   `ASSERT_IMPLIES(a_busy_ready, clock, reset, (state_ff != kts_pkg::ST_IDLE) || (mode_ff == kts_pkg::MODE_CLEAR), (state_ff == kts_pkg::ST_IDLE) || !req_ready)

endmodule
